// ===== hdl/gac_pkg.sv =====
// gac_pkg: shared types, event codes, register indexes and helper functions
// for the greenhouse actuator controller. No dependencies.

package gac_pkg;

  // event kinds carried by an input request
  typedef enum logic [3:0] {
    KIND_AUTO_STEP   = 4'd0,
    KIND_FAN_FOLLOW  = 4'd1,
    KIND_FAN_LEVEL   = 4'd2,
    KIND_REMOTE_FAN  = 4'd3,
    KIND_CURTAIN     = 4'd4,
    KIND_LAMP        = 4'd5,
    KIND_AUTO_MODE   = 4'd6,
    KIND_MANUAL_MODE = 4'd7,
    KIND_RECOVERY    = 4'd8
  } gac_kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_MAX    = 2'd0;
  localparam logic [1:0] REG_LIGHT_UPPER = 2'd1;
  localparam logic [1:0] REG_LIGHT_LOWER = 2'd2;
  localparam logic [1:0] REG_LOCK_DUR    = 2'd3;

  localparam logic signed [11:0] TEMP_MAX_RST    = 12'sd300;
  localparam logic [15:0]        LIGHT_UPPER_RST = 16'd20000;
  localparam logic [15:0]        LIGHT_LOWER_RST = 16'd1000;
  localparam logic [31:0]        LOCK_DUR_RST    = 32'd600000;

  // lockout slots
  localparam int unsigned DEV_FAN     = 0;
  localparam int unsigned DEV_CURTAIN = 1;
  localparam int unsigned DEV_LAMP    = 2;
  localparam int unsigned NUM_DEV     = 3;

  localparam logic [2:0] FAN_LEVEL_MAX = 3'd4;

  typedef struct packed {
    logic [3:0]         kind;
    logic [31:0]        now_ms;
    logic signed [11:0] temperature;
    logic [15:0]        light_lux;
    logic [2:0]         command_value;
  } gac_item_t;

  typedef struct packed {
    logic [2:0] fan_level_out;
    logic       fan_on;
    logic       curtain_open;
    logic       lamp_on;
    logic       system_auto;
    logic       settings_changed;
    logic       status_notify;
  } gac_result_t;

  typedef struct packed {
    logic       fan_auto;
    logic       curtain_auto;
    logic       lamp_auto;
    logic       sys_auto;
    logic       follow;
    logic [2:0] fan_speed;
    logic       fan_run;
    logic       curtain;
    logic       lamp;
    logic [2:0] lock_v;
  } gac_state_t;

  // fan level for a temperature excess d over the comfort limit:
  // 1 + floor(3d/100) for 0 < d < 100, folded into constant compares
  function automatic logic [2:0] level_of(input logic signed [12:0] d);
    logic [2:0] lv;
    if (d <= 13'sd0)       lv = 3'd0;
    else if (d >= 13'sd100) lv = 3'd4;
    else if (d >= 13'sd67)  lv = 3'd3;
    else if (d >= 13'sd34)  lv = 3'd2;
    else                    lv = 3'd1;
    return lv;
  endfunction

  // offset above the comfort limit below which the fan may step down
  function automatic logic [6:0] down_offset(input logic [2:0] lv);
    logic [6:0] off;
    unique case (lv)
      3'd0, 3'd1: off = 7'd0;
      3'd2:       off = 7'd25;
      3'd3:       off = 7'd50;
      default:    off = 7'd75;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/gac_if.sv =====
// gac_if: valid/ready channel interfaces for event requests and results
// depends on gac_pkg

interface gac_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [31:0]        now_ms;
  logic signed [11:0] temperature;
  logic [15:0]        light_lux;
  logic [2:0]         command_value;

  modport source (output valid, kind, now_ms, temperature, light_lux, command_value,
                  input ready);
  modport sink   (input valid, kind, now_ms, temperature, light_lux, command_value,
                  output ready);
endinterface

interface gac_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] fan_level_out;
  logic       fan_on;
  logic       curtain_open;
  logic       lamp_on;
  logic       system_auto;
  logic       settings_changed;
  logic       status_notify;

  modport source (output valid, fan_level_out, fan_on, curtain_open, lamp_on,
                  system_auto, settings_changed, status_notify, input ready);
  modport sink   (input valid, fan_level_out, fan_on, curtain_open, lamp_on,
                  system_auto, settings_changed, status_notify, output ready);
endinterface

// ===== hdl/greenhouse_actuator_controller.sv =====
// greenhouse_actuator_controller: event-driven fan, curtain and grow lamp control
// depends on gac_pkg and the channel interfaces in gac_if.sv

// One event request in, one result out, one request per cycle sustained while results
// are taken. A request lands in an input register; once the result register is empty or
// being drained, the control step (fan level map, lux hysteresis compares, lockout
// checks) runs in one shallow pass and writes the device state and the result register
// together, so a result is valid from the edge on which its step fires. The input register
// refills while a result waits, so the input side only stalls when both the input register
// and the result register are full and the result is not taken. Configuration goes
// through the APB port at byte addresses 0, 4, 8, 12 and must only be written while no
// request is in flight. Every request returns exactly one result holding the
// device state after the event.

module greenhouse_actuator_controller
  import gac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gac_in_if.sink      in_chan,
  gac_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic signed [11:0] temp_max_r;
  logic [15:0]        light_upper_r;
  logic [15:0]        light_lower_r;
  logic [31:0]        lock_dur_r;

  // input register
  logic      s1_v_r;
  gac_item_t s1_r;

  // device state and lockout stamps
  gac_state_t  st_r, st_nxt;
  logic [31:0] stamp_r   [NUM_DEV];
  logic [31:0] stamp_nxt [NUM_DEV];

  // result register
  logic        out_v_r;
  gac_result_t out_r, res_nxt;

  logic advance;
  logic cfg_wr;

  // step datapath
  logic [NUM_DEV-1:0] locked;
  logic signed [12:0] temp_excess;
  logic [2:0]         fan_tgt;
  logic [2:0]         follow_tgt;
  logic [2:0]         cmd_level;
  logic signed [13:0] down_thr;
  logic               fan_step_down_ok;
  logic [18:0]        lux_x5;
  logic [18:0]        upper_x6;
  logic [18:0]        lower_x4;
  logic               lux_above_open;
  logic               lux_below_close;
  logic               lux_below_on;
  logic               lux_above_off;

  // ---------------------------------------------------------------------------
  // configuration port: writes complete in the access phase, pready tied high
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_max_r    <= TEMP_MAX_RST;
      light_upper_r <= LIGHT_UPPER_RST;
      light_lower_r <= LIGHT_LOWER_RST;
      lock_dur_r    <= LOCK_DUR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_TEMP_MAX:    temp_max_r    <= cfg_pwdata[11:0];
        REG_LIGHT_UPPER: light_upper_r <= cfg_pwdata[15:0];
        REG_LIGHT_LOWER: light_lower_r <= cfg_pwdata[15:0];
        default:         lock_dur_r    <= cfg_pwdata;
      endcase
    end
  end

  // read back, comfort limit sign extended
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_TEMP_MAX:    cfg_prdata = {{20{temp_max_r[11]}}, temp_max_r};
      REG_LIGHT_UPPER: cfg_prdata = {16'd0, light_upper_r};
      REG_LIGHT_LOWER: cfg_prdata = {16'd0, light_lower_r};
      default:         cfg_prdata = lock_dur_r;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: the step fires when the input register holds a request and the
  // result register is empty or being drained
  // ---------------------------------------------------------------------------
  assign advance       = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_r.kind          <= in_chan.kind;
      s1_r.now_ms        <= in_chan.now_ms;
      s1_r.temperature   <= in_chan.temperature;
      s1_r.light_lux     <= in_chan.light_lux;
      s1_r.command_value <= in_chan.command_value;
    end
  end

  // ---------------------------------------------------------------------------
  // step datapath
  // ---------------------------------------------------------------------------

  // lockout: armed slot and elapsed time (mod 2^32) still under the duration
  for (genvar g = 0; g < NUM_DEV; g++) begin : g_lock
    assign locked[g] = st_r.lock_v[g] && ((s1_r.now_ms - stamp_r[g]) < lock_dur_r);
  end

  assign temp_excess = 13'(s1_r.temperature) - 13'(temp_max_r);
  assign fan_tgt     = level_of(temp_excess);
  assign follow_tgt  = (fan_tgt == 3'd0) ? 3'd1 : fan_tgt;
  assign cmd_level   = (s1_r.command_value > FAN_LEVEL_MAX) ? FAN_LEVEL_MAX
                                                             : s1_r.command_value;

  // step-down hysteresis, level above four cannot occur but is clamped anyway
  assign down_thr = 14'(temp_max_r)
                  + 14'($signed({1'b0, down_offset((st_r.fan_speed > FAN_LEVEL_MAX)
                                                   ? FAN_LEVEL_MAX : st_r.fan_speed)}));
  assign fan_step_down_ok = 14'(s1_r.temperature) < down_thr;

  // lux thresholds without division:
  // lux > floor(6u/5) <=> 6u < 5 lux, lux > floor(4l/5) <=> 4l < 5 lux
  assign lux_x5   = {1'b0, s1_r.light_lux, 2'b00} + 19'(s1_r.light_lux);
  assign upper_x6 = {1'b0, light_upper_r, 2'b00} + {2'b00, light_upper_r, 1'b0};
  assign lower_x4 = {1'b0, light_lower_r, 2'b00};

  assign lux_above_open  = upper_x6 < lux_x5;
  assign lux_below_close = s1_r.light_lux < (light_upper_r >> 1);
  assign lux_below_on    = s1_r.light_lux < (light_lower_r >> 1);
  assign lux_above_off   = lower_x4 < lux_x5;

  always_comb begin
    st_nxt    = st_r;
    stamp_nxt = stamp_r;
    res_nxt   = '0;

    unique case (s1_r.kind)
      KIND_AUTO_STEP: begin
        if (st_r.fan_auto && !locked[DEV_FAN]) begin
          if ((fan_tgt > st_r.fan_speed) ||
              ((fan_tgt < st_r.fan_speed) && fan_step_down_ok)) begin
            st_nxt.fan_speed         = fan_tgt;
            st_nxt.fan_run           = (fan_tgt != 3'd0);
            res_nxt.settings_changed = 1'b1;
            res_nxt.status_notify    = 1'b1;
          end
        end
        if (st_r.curtain_auto && !locked[DEV_CURTAIN]) begin
          if (!st_r.curtain && lux_above_open) begin
            st_nxt.curtain           = 1'b1;
            res_nxt.settings_changed = 1'b1;
          end else if (st_r.curtain && lux_below_close) begin
            st_nxt.curtain           = 1'b0;
            res_nxt.settings_changed = 1'b1;
          end
        end
        if (st_r.lamp_auto && !locked[DEV_LAMP]) begin
          if (!st_r.lamp && lux_below_on) begin
            st_nxt.lamp              = 1'b1;
            res_nxt.settings_changed = 1'b1;
          end else if (st_r.lamp && lux_above_off) begin
            st_nxt.lamp              = 1'b0;
            res_nxt.settings_changed = 1'b1;
          end
        end
      end

      KIND_FAN_FOLLOW: begin
        if (st_r.follow && st_r.fan_run && !locked[DEV_FAN] &&
            (follow_tgt != st_r.fan_speed)) begin
          st_nxt.fan_speed         = follow_tgt;
          res_nxt.settings_changed = 1'b1;
        end
      end

      KIND_FAN_LEVEL: begin
        st_nxt.fan_auto             = 1'b0;
        st_nxt.sys_auto             = 1'b0;
        st_nxt.follow               = 1'b0;
        st_nxt.fan_speed            = cmd_level;
        st_nxt.fan_run              = (cmd_level != 3'd0);
        st_nxt.lock_v[DEV_FAN]      = (cmd_level == 3'd0);
        stamp_nxt[DEV_FAN]          = s1_r.now_ms;
      end

      KIND_REMOTE_FAN: begin
        st_nxt.fan_auto = 1'b0;
        st_nxt.sys_auto = 1'b0;
        if (s1_r.command_value == 3'd1) begin
          st_nxt.fan_speed       = follow_tgt;
          st_nxt.fan_run         = 1'b1;
          st_nxt.follow          = 1'b1;
          st_nxt.lock_v[DEV_FAN] = 1'b0;
        end else begin
          st_nxt.fan_speed       = 3'd0;
          st_nxt.fan_run         = 1'b0;
          st_nxt.follow          = 1'b0;
          st_nxt.lock_v[DEV_FAN] = 1'b1;
          stamp_nxt[DEV_FAN]     = s1_r.now_ms;
        end
      end

      KIND_CURTAIN: begin
        st_nxt.curtain_auto        = 1'b0;
        st_nxt.sys_auto            = 1'b0;
        st_nxt.curtain             = (s1_r.command_value != 3'd0);
        st_nxt.lock_v[DEV_CURTAIN] = (s1_r.command_value == 3'd0);
        stamp_nxt[DEV_CURTAIN]     = s1_r.now_ms;
      end

      KIND_LAMP: begin
        st_nxt.lamp_auto        = 1'b0;
        st_nxt.sys_auto         = 1'b0;
        st_nxt.lamp             = (s1_r.command_value != 3'd0);
        st_nxt.lock_v[DEV_LAMP] = (s1_r.command_value == 3'd0);
        stamp_nxt[DEV_LAMP]     = s1_r.now_ms;
      end

      KIND_AUTO_MODE: begin
        st_nxt.fan_auto     = 1'b1;
        st_nxt.curtain_auto = 1'b1;
        st_nxt.lamp_auto    = 1'b1;
        st_nxt.sys_auto     = 1'b1;
        st_nxt.follow       = 1'b0;
        st_nxt.lock_v       = '0;
      end

      KIND_MANUAL_MODE: begin
        st_nxt.fan_auto     = 1'b0;
        st_nxt.curtain_auto = 1'b0;
        st_nxt.lamp_auto    = 1'b0;
        st_nxt.sys_auto     = 1'b0;
        st_nxt.follow       = 1'b0;
      end

      KIND_RECOVERY: begin
        // nightly recovery only acts when something is in manual
        if (!st_r.sys_auto) begin
          st_nxt.fan_auto     = 1'b1;
          st_nxt.curtain_auto = 1'b1;
          st_nxt.lamp_auto    = 1'b1;
          st_nxt.sys_auto     = 1'b1;
          st_nxt.follow       = 1'b0;
          st_nxt.lock_v       = '0;
        end
      end

      default: begin
        // unused kinds leave everything as is
      end
    endcase

    res_nxt.fan_level_out = st_nxt.fan_speed;
    res_nxt.fan_on        = st_nxt.fan_run;
    res_nxt.curtain_open  = st_nxt.curtain;
    res_nxt.lamp_on       = st_nxt.lamp;
    res_nxt.system_auto   = st_nxt.sys_auto;
  end

  // ---------------------------------------------------------------------------
  // state and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{fan_auto: 1'b1, curtain_auto: 1'b1, lamp_auto: 1'b1, sys_auto: 1'b1,
                follow: 1'b0, fan_speed: 3'd0, fan_run: 1'b0, curtain: 1'b0,
                lamp: 1'b0, lock_v: 3'b000};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // stamps only matter while their slot is armed
  always_ff @(posedge clk) begin
    if (advance) begin
      stamp_r <= stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_chan.valid            = out_v_r;
  assign out_chan.fan_level_out    = out_r.fan_level_out;
  assign out_chan.fan_on           = out_r.fan_on;
  assign out_chan.curtain_open     = out_r.curtain_open;
  assign out_chan.lamp_on          = out_r.lamp_on;
  assign out_chan.system_auto      = out_r.system_auto;
  assign out_chan.settings_changed = out_r.settings_changed;
  assign out_chan.status_notify    = out_r.status_notify;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // running flag always tracks a nonzero level
  a_fan_run_level: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fan_run == (st_r.fan_speed != 3'd0))
    else $error("fan running flag disagrees with fan level");

  a_fan_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fan_speed <= FAN_LEVEL_MAX)
    else $error("fan level above maximum");

  // whole-system auto implies every device auto and no fan follow
  a_sys_auto: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.sys_auto |-> (st_r.fan_auto && st_r.curtain_auto && st_r.lamp_auto &&
                       !st_r.follow))
    else $error("system auto set with a device in manual");

  a_notify_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status_notify) |-> out_r.settings_changed)
    else $error("status notify without settings change");

  // a completed step must leave a result pending
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("step fired but no result held");

endmodule

// ===== sim/greenhouse_actuator_controller_checker.sv =====
// greenhouse_actuator_controller_checker: watches the request, result and APB
// ports, predicts each result from its own copy of the controller state and compares.
// depends on gac_pkg and the channel interfaces in gac_if.sv

module greenhouse_actuator_controller_checker
  import gac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gac_in_if           in_chan,
  gac_out_if          out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          changes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // register copies
  logic signed [11:0] temp_limit;
  logic [15:0]        lux_upper;
  logic [15:0]        lux_lower;
  logic [31:0]        lock_len;

  // controller state copies
  logic       fan_auto, curtain_auto, lamp_auto, sys_auto, follow_on;
  logic [2:0] fan_lvl;
  logic       fan_run, curtain_up, lamp_lit;
  logic [31:0] lock_at [NUM_DEV];
  logic        lock_on [NUM_DEV];

  gac_result_t expected_states[$];

  function automatic logic is_locked(int unsigned dev, logic [31:0] now);
    logic [31:0] age;
    age = now - lock_at[dev];
    return lock_on[dev] && (age < lock_len);
  endfunction

  function automatic logic [2:0] temp_level(logic signed [11:0] t);
    int d;
    d = int'(t) - int'(temp_limit);
    if (d <= 0) return 3'd0;
    if (d >= 100) return FAN_LEVEL_MAX;
    return 3'(1 + (3 * d) / 100);
  endfunction

  function automatic string show(gac_result_t r);
    return $sformatf("lvl %0d fan %b curtain %b lamp %b auto %b chg %b ntf %b",
                     r.fan_level_out, r.fan_on, r.curtain_open, r.lamp_on,
                     r.system_auto, r.settings_changed, r.status_notify);
  endfunction

  task automatic set_lock(int unsigned dev, logic on, logic [31:0] now);
    lock_on[dev] = on;
    lock_at[dev] = on ? now : '0;
  endtask

  task automatic enter_auto();
    fan_auto = 1'b1;
    curtain_auto = 1'b1;
    lamp_auto = 1'b1;
    sys_auto = 1'b1;
    follow_on = 1'b0;
    for (int i = 0; i < NUM_DEV; i++) set_lock(i, 1'b0, '0);
  endtask

  task automatic reset_state();
    temp_limit = TEMP_MAX_RST;
    lux_upper = LIGHT_UPPER_RST;
    lux_lower = LIGHT_LOWER_RST;
    lock_len = LOCK_DUR_RST;
    enter_auto();
    fan_lvl = '0;
    fan_run = 1'b0;
    curtain_up = 1'b0;
    lamp_lit = 1'b0;
    expected_states.delete();
  endtask

  task automatic predict_event(input gac_item_t ev, output gac_result_t res);
    logic [2:0]  want;
    logic        touched, fan_moved, step_ok;
    int          floor_at;
    logic [31:0] open_at, close_at, lit_at, dark_at, lux;
    touched = 1'b0;
    fan_moved = 1'b0;
    lux = 32'(ev.light_lux);
    case (ev.kind)
      KIND_AUTO_STEP: begin
        if (fan_auto && !is_locked(DEV_FAN, ev.now_ms)) begin
          want = temp_level(ev.temperature);
          step_ok = want > fan_lvl;
          if (want < fan_lvl) begin
            // stepping down needs the temperature under this level's floor
            floor_at = int'(temp_limit) + 25 * (int'(fan_lvl) - 1);
            step_ok = int'(ev.temperature) < floor_at;
          end
          if (step_ok) begin
            fan_lvl = want;
            fan_run = (want != 3'd0);
            touched = 1'b1;
            fan_moved = 1'b1;
          end
        end
        if (curtain_auto && !is_locked(DEV_CURTAIN, ev.now_ms)) begin
          open_at = (32'(lux_upper) * 6) / 5;
          close_at = 32'(lux_upper) / 2;
          if (!curtain_up && lux > open_at) begin
            curtain_up = 1'b1;
            touched = 1'b1;
          end else if (curtain_up && lux < close_at) begin
            curtain_up = 1'b0;
            touched = 1'b1;
          end
        end
        if (lamp_auto && !is_locked(DEV_LAMP, ev.now_ms)) begin
          lit_at = 32'(lux_lower) / 2;
          dark_at = (32'(lux_lower) * 4) / 5;
          if (!lamp_lit && lux < lit_at) begin
            lamp_lit = 1'b1;
            touched = 1'b1;
          end else if (lamp_lit && lux > dark_at) begin
            lamp_lit = 1'b0;
            touched = 1'b1;
          end
        end
      end
      KIND_FAN_FOLLOW: begin
        if (follow_on && fan_run && !is_locked(DEV_FAN, ev.now_ms)) begin
          want = temp_level(ev.temperature);
          if (want == 3'd0) want = 3'd1;
          if (want != fan_lvl) begin
            fan_lvl = want;
            touched = 1'b1;
          end
        end
      end
      KIND_FAN_LEVEL: begin
        want = (ev.command_value > FAN_LEVEL_MAX) ? FAN_LEVEL_MAX : ev.command_value;
        fan_auto = 1'b0;
        sys_auto = 1'b0;
        follow_on = 1'b0;
        fan_lvl = want;
        fan_run = (want != 3'd0);
        set_lock(DEV_FAN, want == 3'd0, ev.now_ms);
      end
      KIND_REMOTE_FAN: begin
        fan_auto = 1'b0;
        sys_auto = 1'b0;
        if (ev.command_value == 3'd1) begin
          want = temp_level(ev.temperature);
          if (want == 3'd0) want = 3'd1;
          fan_lvl = want;
          fan_run = 1'b1;
          follow_on = 1'b1;
          set_lock(DEV_FAN, 1'b0, ev.now_ms);
        end else begin
          fan_lvl = '0;
          fan_run = 1'b0;
          follow_on = 1'b0;
          set_lock(DEV_FAN, 1'b1, ev.now_ms);
        end
      end
      KIND_CURTAIN: begin
        curtain_auto = 1'b0;
        sys_auto = 1'b0;
        curtain_up = (ev.command_value != 3'd0);
        set_lock(DEV_CURTAIN, ev.command_value == 3'd0, ev.now_ms);
      end
      KIND_LAMP: begin
        lamp_auto = 1'b0;
        sys_auto = 1'b0;
        lamp_lit = (ev.command_value != 3'd0);
        set_lock(DEV_LAMP, ev.command_value == 3'd0, ev.now_ms);
      end
      KIND_AUTO_MODE: enter_auto();
      KIND_MANUAL_MODE: begin
        fan_auto = 1'b0;
        curtain_auto = 1'b0;
        lamp_auto = 1'b0;
        sys_auto = 1'b0;
        follow_on = 1'b0;
      end
      KIND_RECOVERY: begin
        if (!sys_auto) enter_auto();
      end
      default: ;
    endcase
    res = '{fan_level_out: fan_lvl, fan_on: fan_run, curtain_open: curtain_up,
            lamp_on: lamp_lit, system_auto: sys_auto, settings_changed: touched,
            status_notify: fan_moved};
  endtask

  always @(posedge clk) begin
    gac_item_t   ev;
    gac_result_t want_r, got_r;
    if (!rst_n) begin
      reset_state();
    end else begin
      // results first, so a stray result is never matched with this edge's request
      if (out_chan.valid && out_chan.ready) begin
        got_r = '{fan_level_out: out_chan.fan_level_out, fan_on: out_chan.fan_on,
                  curtain_open: out_chan.curtain_open, lamp_on: out_chan.lamp_on,
                  system_auto: out_chan.system_auto,
                  settings_changed: out_chan.settings_changed,
                  status_notify: out_chan.status_notify};
        results_seen++;
        if (expected_states.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("[%0t] result with nothing pending: %s", $realtime, show(got_r));
        end else begin
          want_r = expected_states.pop_front();
          if (want_r != got_r) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("[%0t] result %0d mismatch", $realtime, results_seen);
              $display("  expected %s", show(want_r));
              $display("  actual   %s", show(got_r));
            end
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        ev.kind = in_chan.kind;
        ev.now_ms = in_chan.now_ms;
        ev.temperature = in_chan.temperature;
        ev.light_lux = in_chan.light_lux;
        ev.command_value = in_chan.command_value;
        predict_event(ev, want_r);
        if (want_r.settings_changed) changes_seen++;
        expected_states.push_back(want_r);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_TEMP_MAX:    temp_limit = cfg_pwdata[11:0];
          REG_LIGHT_UPPER: lux_upper = cfg_pwdata[15:0];
          REG_LIGHT_LOWER: lux_lower = cfg_pwdata[15:0];
          REG_LOCK_DUR:    lock_len = cfg_pwdata;
          default: ;
        endcase
      end
    end
    pending = expected_states.size();
  end

endmodule

// ===== sim/greenhouse_actuator_controller_tb.sv =====
// greenhouse_actuator_controller_tb: stimulus and verdict for the actuator controller
// drives event requests, APB register writes and result back-pressure; checking is
// done by greenhouse_actuator_controller_checker. depends on gac_pkg and gac_if.sv

module greenhouse_actuator_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gac_pkg::*;

  localparam int         ITEMS_PER_PHASE   = 250;
  localparam int         NUM_PHASES        = 7;
  localparam int         HOLD_CYCLES       = 64;
  localparam int         DRAIN_LIMIT       = 5000;
  // kind codes the block does not decode
  localparam logic [3:0] FIRST_UNUSED_KIND = 4'd9;
  localparam logic [3:0] LAST_KIND_CODE    = 4'd15;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gac_in_if  in_chan ();
  gac_out_if out_chan ();

  // pacing knobs, percent of cycles idle on each side
  int send_gap_pct = 11;
  int recv_stall_pct = 49;
  // long receiver hold-off, requested by the stimulus and counted by the receiver
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int chk_fails, chk_pending, chk_results, chk_changes;
  int sent_count = 0;
  int drain_wait;

  // register values as last written, used to aim requests at thresholds
  int          cur_tmax, cur_lupper, cur_llower;
  logic [31:0] cur_lockdur;
  logic [31:0] tick, last_off_tick;

  greenhouse_actuator_controller DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  greenhouse_actuator_controller_checker state_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .fail_count   (chk_fails),
    .pending      (chk_pending),
    .results_seen (chk_results),
    .changes_seen (chk_changes)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", chk_pending);
    $display("** greenhouse_actuator_controller: FAILED **");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // one request: optional idle gap, then hold valid until the block takes it;
  // called and returns at a falling edge
  task automatic send_event(input logic [3:0] k, input logic [31:0] now, input int temp,
                            input int lux, input logic [2:0] cmd);
    while ($urandom_range(99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= k;
    in_chan.now_ms <= now;
    in_chan.temperature <= 12'(temp);
    in_chan.light_lux <= 16'(lux);
    in_chan.command_value <= cmd;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  // wait until every request has its result, then let the pipeline settle
  task automatic wait_drained();
    while (chk_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // back-to-back APB writes of all four registers; psel stays up between them
  task automatic configure(input int tmax, input int lupper, input int llower,
                           input logic [31:0] lockdur);
    logic [31:0] vals [4];
    vals[REG_TEMP_MAX] = 32'(tmax);
    vals[REG_LIGHT_UPPER] = 32'(lupper);
    vals[REG_LIGHT_LOWER] = 32'(llower);
    vals[REG_LOCK_DUR] = lockdur;
    cur_tmax = tmax;
    cur_lupper = lupper;
    cur_llower = llower;
    cur_lockdur = lockdur;
    for (int i = 0; i < 4; i++) begin
      // setup cycle
      cfg_psel <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b1;
      cfg_paddr <= 4'(i) << 2;
      cfg_pwdata <= vals[i];
      @(negedge clk);
      // access cycle, register takes the value at the edge with pready high
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      @(negedge clk);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // hand-picked requests at the default register values (limit 30.0 C,
  // curtain opens above 24000 lux and closes below 10000, lamp on below 500
  // and off above 800)
  task automatic directed_events();
    send_event(KIND_AUTO_STEP, 32'd0, 300, 10000, 3'd0);   // at limit, nothing moves
    send_event(KIND_AUTO_STEP, 32'd5, 301, 10000, 3'd0);   // just over, fan level 1
    send_event(KIND_AUTO_STEP, 32'd10, 400, 24001, 3'd0);  // full excess, curtain opens
    send_event(KIND_AUTO_STEP, 32'd20, 374, 9999, 3'd0);   // under level-4 floor, curtain shuts
    send_event(KIND_AUTO_STEP, 32'd30, 2047, 499, 3'd0);   // top of field, lamp on
    send_event(KIND_AUTO_STEP, 32'd40, -2048, 801, 3'd0);  // bottom of field, fan and lamp off
    send_event(KIND_FAN_LEVEL, 32'd50, 300, 0, 3'd7);      // level above range, clamped
    send_event(KIND_FAN_FOLLOW, 32'd60, 350, 0, 3'd0);     // follow not enabled
    send_event(KIND_REMOTE_FAN, 32'd70, 300, 0, 3'd1);     // remote on, follow armed
    send_event(KIND_FAN_FOLLOW, 32'd80, 367, 0, 3'd0);     // follow up to level 3
    send_event(KIND_FAN_FOLLOW, 32'd90, 200, 0, 3'd0);     // follow floor is level 1
    send_event(KIND_REMOTE_FAN, 32'd100, 300, 0, 3'd2);    // any value but one is off
    send_event(KIND_CURTAIN, 32'd110, 300, 0, 3'd5);       // nonzero means open
    send_event(KIND_LAMP, 32'd120, 300, 0, 3'd0);          // lamp off starts a lockout
    send_event(KIND_AUTO_STEP, 32'd130, 500, 0, 3'd0);     // devices manual, auto step idle
    send_event(KIND_MANUAL_MODE, 32'd140, 300, 0, 3'd0);
    send_event(KIND_RECOVERY, 32'd150, 300, 0, 3'd0);      // back to auto
    send_event(KIND_RECOVERY, 32'd160, 300, 0, 3'd0);      // already auto, no effect
    send_event(LAST_KIND_CODE, 32'd165, 300, 0, 3'd7);     // undecoded kinds
    send_event(FIRST_UNUSED_KIND, 32'd166, 300, 0, 3'd7);
    send_event(KIND_AUTO_MODE, 32'd170, 300, 0, 3'd0);
    send_event(KIND_AUTO_STEP, 32'hFFFF_FFFF, -400, 65535, 3'd0);
    send_event(KIND_AUTO_STEP, 32'd0, 1250, 0, 3'd0);
    send_event(KIND_FAN_LEVEL, 32'd0, 300, 0, 3'd0);       // switch-off at tick zero
    send_event(KIND_REMOTE_FAN, 32'd599_999, 300, 0, 3'd3);
  endtask

  // one random request, weighted toward auto steps and aimed at the thresholds
  task automatic random_event();
    logic [3:0] k;
    logic [2:0] cmd;
    int         pick, temp, lux;
    pick = $urandom_range(99);
    if (pick < 40) k = KIND_AUTO_STEP;
    else if (pick < 52) k = KIND_FAN_FOLLOW;
    else if (pick < 59) k = KIND_FAN_LEVEL;
    else if (pick < 68) k = KIND_REMOTE_FAN;
    else if (pick < 74) k = KIND_CURTAIN;
    else if (pick < 80) k = KIND_LAMP;
    else if (pick < 86) k = KIND_AUTO_MODE;
    else if (pick < 90) k = KIND_MANUAL_MODE;
    else if (pick < 96) k = KIND_RECOVERY;
    else k = 4'($urandom_range(LAST_KIND_CODE, FIRST_UNUSED_KIND));

    // time mostly creeps forward, sometimes jumps, wraps or lands on lockout expiry
    case ($urandom_range(19))
      0: tick = $urandom();
      1: tick = 32'hFFFF_FFFF - $urandom_range(50);
      2, 3: tick = last_off_tick + cur_lockdur - 32'd2 + $urandom_range(4);
      default: tick = tick + $urandom_range(400);
    endcase

    case ($urandom_range(9))
      0: temp = int'($signed(12'($urandom())));
      1: temp = int'($urandom_range(1650)) - 400;
      default: temp = cur_tmax + int'($urandom_range(260)) - 130;
    endcase
    temp = clamp(temp, -2048, 2047);

    case ($urandom_range(5))
      0: lux = int'($urandom_range(65535));
      1: lux = (cur_lupper * 6) / 5;
      2: lux = cur_lupper / 2;
      3: lux = cur_llower / 2;
      4: lux = (cur_llower * 4) / 5;
      default: lux = int'($urandom_range(2 * cur_llower));
    endcase
    lux = clamp(lux + int'($urandom_range(6)) - 3, 0, 65535);

    if (k == KIND_REMOTE_FAN && $urandom_range(1)) cmd = 3'($urandom_range(1));
    else cmd = 3'($urandom_range(7));
    if (cmd == 3'd0 || (k == KIND_REMOTE_FAN && cmd != 3'd1)) last_off_tick = tick;

    send_event(k, tick, temp, lux, cmd);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.kind = KIND_AUTO_STEP;
    in_chan.now_ms = '0;
    in_chan.temperature = '0;
    in_chan.light_lux = '0;
    in_chan.command_value = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_tmax = int'(TEMP_MAX_RST);
    cur_lupper = int'(LIGHT_UPPER_RST);
    cur_llower = int'(LIGHT_LOWER_RST);
    cur_lockdur = LOCK_DUR_RST;
    tick = '0;
    last_off_tick = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests run at the reset register values
    directed_events();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // registers only change with nothing in flight
      in_chan.valid <= 1'b0;
      wait_drained();
      case (ph)
        0: configure(300, 20000, 1000, 32'd500);
        1: configure(-400, 0, 0, 32'd0);
        2: configure(1250, 65535, 65535, 32'hFFFF_FFFF);
        4: configure(0, 100, 50, 32'd1);
        6: configure(int'($urandom_range(1650)) - 400, int'($urandom_range(65535)),
                     int'($urandom_range(65535)), $urandom());
        default: configure(int'($urandom_range(1650)) - 400, int'($urandom_range(65535)),
                           int'($urandom_range(65535)), $urandom_range(3000));
      endcase

      // pacing: sender light / receiver heavy, then swapped, then full rate
      if (ph < 2) begin
        send_gap_pct = 11;
        recv_stall_pct = 49;
      end else if (ph < 4) begin
        send_gap_pct = 49;
        recv_stall_pct = 11;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long result hold-off while requests keep coming, so the input backs up
        if (n == ITEMS_PER_PHASE / 4 && (ph == 1 || ph == 4)) hold_asks++;
        // sender pause until all outstanding results are back
        if (n == ITEMS_PER_PHASE / 2 && ph == 2) begin
          in_chan.valid <= 1'b0;
          wait_drained();
        end
        random_event();
      end
    end
    in_chan.valid <= 1'b0;

    drain_wait = 0;
    while (chk_pending != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    // a few more cycles so a stray extra result would still be caught
    repeat (8) @(posedge clk);

    $display("covered %0d requests across %0d register settings and three pacing modes",
             sent_count, NUM_PHASES + 1);
    $display("checked %0d results, %0d with a state change, %0d still outstanding",
             chk_results, chk_changes, chk_pending);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("** greenhouse_actuator_controller: PASSED **");
    end else begin
      $display("** greenhouse_actuator_controller: FAILED **");
    end
    $finish;
  end

endmodule

// ===== greenhouse_actuator_controller.f =====
hdl/gac_pkg.sv
hdl/gac_if.sv
hdl/greenhouse_actuator_controller.sv
sim/greenhouse_actuator_controller_checker.sv
sim/greenhouse_actuator_controller_tb.sv
